// ===== hw/rtl/cetd_pkg.sv =====
// ----------------------------------------------------------------------------
// cetd_pkg: shared definitions for the escape token decoder
// Character codes, escape states, the result beat layout and small
// character-class helpers.
// ----------------------------------------------------------------------------
package cetd_pkg;

   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;

   localparam int unsigned MAX_BEATS = 3;

   typedef enum logic [3:0] {
      ESC_PLAIN     = 4'b0001,
      ESC_BACKSLASH = 4'b0010,
      ESC_HEX0      = 4'b0100,
      ESC_HEX1      = 4'b1000
   } esc_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       token_end;
      logic       last;
   } beat_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      if (c inside {[8'h30:8'h39]}) begin
         v = c - 8'h30;
      end else if (c inside {[8'h61:8'h66]}) begin
         v = c - 8'h57;
      end else begin
         v = c - 8'h37;
      end
      hex_val = v[3:0];
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == CHAR_SPACE) || (c inside {[8'h09:8'h0D]});
   endfunction

endpackage

// ===== hw/rtl/c_escape_token_decoder_unit.sv =====
// The first result beat of an input beat appears on rsp_ the cycle after it is taken.
// Throughput: one input beat per cycle while each beat yields at most one result
// and rsp_stall is low; a beat with two or three results holds the input until
// the three-entry buffer, drained one entry per unstalled cycle, is down to one.
// Reset clears the escape state, quoted mode and the result buffer (rsp_valid low).
// ----------------------------------------------------------------------------
// c_escape_token_decoder_unit: backslash-escape token decoder
// Decodes one text byte per beat into zero to three result beats: escape
// expansion, hex escapes, quote stripping and whitespace token closing.
// ----------------------------------------------------------------------------
module c_escape_token_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_token_end,
   output logic       rsp_last
);

   cetd_pkg::esc_type  mode_ff, mode_in;
   logic [3:0]         accum_ff, accum_in;
   logic               quotes_ff, quotes_in;

   cetd_pkg::beat_type buf_ff [cetd_pkg::MAX_BEATS];
   cetd_pkg::beat_type buf_in [cetd_pkg::MAX_BEATS];
   logic [1:0]         rem_ff, rem_in;

   cetd_pkg::beat_type lst [cetd_pkg::MAX_BEATS];
   logic [1:0]         cnt;
   logic               run_plain;
   logic               accept;
   logic               pop;
   logic               c_hex;
   logic [3:0]         c_val;

   assign c_hex = cetd_pkg::is_hex(req_in_byte);
   assign c_val = cetd_pkg::hex_val(req_in_byte);

   // decode one input beat into up to three result beats
   always_comb begin
      for (int i = 0; i < cetd_pkg::MAX_BEATS; i++) begin
         lst[i] = '0;
      end
      cnt       = 2'd0;
      run_plain = 1'b0;
      mode_in   = mode_ff;
      accum_in  = accum_ff;
      quotes_in = quotes_ff;

      if (req_end_of_input) begin
         case (mode_ff)
            cetd_pkg::ESC_BACKSLASH: begin
               lst[cnt] = '{cetd_pkg::CHAR_BACKSLASH, 1'b1, 1'b0, 1'b0};
               cnt      = cnt + 2'd1;
            end
            cetd_pkg::ESC_HEX0: begin
               lst[cnt] = '{cetd_pkg::CHAR_BACKSLASH, 1'b1, 1'b0, 1'b0};
               cnt      = cnt + 2'd1;
               lst[cnt] = '{cetd_pkg::CHAR_X, 1'b1, 1'b0, 1'b0};
               cnt      = cnt + 2'd1;
            end
            cetd_pkg::ESC_HEX1: begin
               lst[cnt] = '{{4'h0, accum_ff}, 1'b1, 1'b0, 1'b0};
               cnt      = cnt + 2'd1;
            end
            default: begin
            end
         endcase
         lst[cnt]  = '{8'h00, 1'b0, 1'b1, 1'b0};
         cnt       = cnt + 2'd1;
         mode_in   = cetd_pkg::ESC_PLAIN;
         accum_in  = 4'h0;
         quotes_in = 1'b0;
      end else begin
         case (mode_ff)
            cetd_pkg::ESC_PLAIN: begin
               run_plain = 1'b1;
            end
            cetd_pkg::ESC_BACKSLASH: begin
               mode_in = cetd_pkg::ESC_PLAIN;
               if (req_in_byte == cetd_pkg::CHAR_T) begin
                  lst[cnt] = '{cetd_pkg::CHAR_TAB, 1'b1, 1'b0, 1'b0};
                  cnt      = cnt + 2'd1;
               end else if (req_in_byte == cetd_pkg::CHAR_N) begin
                  lst[cnt] = '{cetd_pkg::CHAR_LF, 1'b1, 1'b0, 1'b0};
                  cnt      = cnt + 2'd1;
               end else if (req_in_byte == cetd_pkg::CHAR_R) begin
                  lst[cnt] = '{cetd_pkg::CHAR_CR, 1'b1, 1'b0, 1'b0};
                  cnt      = cnt + 2'd1;
               end else if (req_in_byte == cetd_pkg::CHAR_X) begin
                  mode_in = cetd_pkg::ESC_HEX0;
               end else begin
                  lst[cnt] = '{req_in_byte, 1'b1, 1'b0, 1'b0};
                  cnt      = cnt + 2'd1;
               end
            end
            cetd_pkg::ESC_HEX0: begin
               if (c_hex) begin
                  accum_in = c_val;
                  mode_in  = cetd_pkg::ESC_HEX1;
               end else begin
                  lst[cnt]  = '{cetd_pkg::CHAR_BACKSLASH, 1'b1, 1'b0, 1'b0};
                  cnt       = cnt + 2'd1;
                  lst[cnt]  = '{cetd_pkg::CHAR_X, 1'b1, 1'b0, 1'b0};
                  cnt       = cnt + 2'd1;
                  run_plain = 1'b1;
               end
            end
            cetd_pkg::ESC_HEX1: begin
               if (c_hex) begin
                  lst[cnt] = '{{accum_ff, c_val}, 1'b1, 1'b0, 1'b0};
                  cnt      = cnt + 2'd1;
                  mode_in  = cetd_pkg::ESC_PLAIN;
                  accum_in = 4'h0;
               end else begin
                  lst[cnt]  = '{{4'h0, accum_ff}, 1'b1, 1'b0, 1'b0};
                  cnt       = cnt + 2'd1;
                  run_plain = 1'b1;
               end
            end
            default: begin
               run_plain = 1'b1;
            end
         endcase

         // the byte is decoded from plain mode
         if (run_plain) begin
            mode_in  = cetd_pkg::ESC_PLAIN;
            accum_in = 4'h0;
            if (req_in_byte == cetd_pkg::CHAR_BACKSLASH) begin
               mode_in = cetd_pkg::ESC_BACKSLASH;
            end else if (req_in_byte == cetd_pkg::CHAR_QUOTE) begin
               quotes_in = !quotes_ff;
            end else if (cetd_pkg::is_space(req_in_byte) && !quotes_ff) begin
               lst[cnt]  = '{8'h00, 1'b0, 1'b1, 1'b0};
               cnt       = cnt + 2'd1;
               quotes_in = 1'b0;
            end else begin
               lst[cnt] = '{req_in_byte, 1'b1, 1'b0, 1'b0};
               cnt      = cnt + 2'd1;
            end
         end
      end

      for (int i = 0; i < cetd_pkg::MAX_BEATS; i++) begin
         lst[i].last = (cnt != 2'd0) && (2'(i) == (cnt - 2'd1));
      end
   end

   // result buffer: head at entry 0, shift down on each delivered beat
   assign rsp_valid = (rem_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = !((rem_ff == 2'd0) || ((rem_ff == 2'd1) && pop));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      rem_in = rem_ff;
      for (int i = 0; i < cetd_pkg::MAX_BEATS; i++) begin
         buf_in[i] = buf_ff[i];
      end
      if (accept) begin
         rem_in = cnt;
         for (int i = 0; i < cetd_pkg::MAX_BEATS; i++) begin
            buf_in[i] = lst[i];
         end
      end else if (pop) begin
         rem_in = rem_ff - 2'd1;
         for (int i = 0; i < cetd_pkg::MAX_BEATS - 1; i++) begin
            buf_in[i] = buf_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff    <= 2'd0;
         mode_ff   <= cetd_pkg::ESC_PLAIN;
         accum_ff  <= 4'h0;
         quotes_ff <= 1'b0;
      end else begin
         rem_ff <= rem_in;
         if (accept) begin
            mode_ff   <= mode_in;
            accum_ff  <= accum_in;
            quotes_ff <= quotes_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < cetd_pkg::MAX_BEATS; i++) begin
         buf_ff[i] <= buf_in[i];
      end
   end

   assign rsp_out_byte   = buf_ff[0].out_byte;
   assign rsp_byte_valid = buf_ff[0].byte_valid;
   assign rsp_token_end  = buf_ff[0].token_end;
   assign rsp_last       = buf_ff[0].last;

endmodule

// ===== tb/token_decode_predictor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// token_decode_predictor: result prediction and comparison for the decoder
// Watches both channels of the escape token decoder. Every accepted input beat
// runs through an independent model of the escape state machine, which queues
// the result beats it should produce. Each accepted result beat is compared
// field by field with the oldest queued beat.
// ----------------------------------------------------------------------------
module token_decode_predictor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_input,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_byte_valid,
   input  logic        rsp_token_end,
   input  logic        rsp_last,
   output int unsigned error_count,
   output int unsigned pending_beats,
   output int unsigned checked_beats,
   output int unsigned token_closes
);

   cetd_pkg::esc_type  esc_state;
   logic [3:0]         hex_hi;
   logic               quoted;
   cetd_pkg::beat_type expected_beats[$];

   initial begin
      error_count   = 0;
      pending_beats = 0;
      checked_beats = 0;
      token_closes  = 0;
      esc_state     = cetd_pkg::ESC_PLAIN;
      hex_hi        = '0;
      quoted        = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      error_count++;
   endtask

   // -1 when the byte is not a hex digit
   function automatic int hex_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function automatic bit blank(input logic [7:0] c);
      return (c == cetd_pkg::CHAR_SPACE) ||
             (c >= cetd_pkg::CHAR_TAB && c <= cetd_pkg::CHAR_CR);
   endfunction

   task automatic add_beat(input logic [7:0] b, input logic byte_ok, input logic closes);
      cetd_pkg::beat_type t;
      t.out_byte   = b;
      t.byte_valid = byte_ok;
      t.token_end  = closes;
      t.last       = 1'b0;
      expected_beats.push_back(t);
   endtask

   task automatic close_token();
      add_beat(8'h00, 1'b0, 1'b1);
      esc_state = cetd_pkg::ESC_PLAIN;
      hex_hi    = '0;
      quoted    = 1'b0;
   endtask

   task automatic take_plain(input logic [7:0] c);
      esc_state = cetd_pkg::ESC_PLAIN;
      hex_hi    = '0;
      if (c == cetd_pkg::CHAR_BACKSLASH) begin
         esc_state = cetd_pkg::ESC_BACKSLASH;
      end else if (c == cetd_pkg::CHAR_QUOTE) begin
         quoted = ~quoted;
      end else if (blank(c) && !quoted) begin
         close_token();
      end else begin
         add_beat(c, 1'b1, 1'b0);
      end
   endtask

   task automatic predict_beat(input logic [7:0] c, input logic eoi);
      int                 start_size;
      int                 h;
      cetd_pkg::beat_type t;
      start_size = expected_beats.size();
      if (eoi) begin
         // flush whatever escape is pending, then close
         case (esc_state)
            cetd_pkg::ESC_BACKSLASH: add_beat(cetd_pkg::CHAR_BACKSLASH, 1'b1, 1'b0);
            cetd_pkg::ESC_HEX0: begin
               add_beat(cetd_pkg::CHAR_BACKSLASH, 1'b1, 1'b0);
               add_beat(cetd_pkg::CHAR_X, 1'b1, 1'b0);
            end
            cetd_pkg::ESC_HEX1: add_beat({4'h0, hex_hi}, 1'b1, 1'b0);
            default: ;
         endcase
         close_token();
      end else begin
         case (esc_state)
            cetd_pkg::ESC_BACKSLASH: begin
               esc_state = cetd_pkg::ESC_PLAIN;
               if (c == cetd_pkg::CHAR_T) add_beat(cetd_pkg::CHAR_TAB, 1'b1, 1'b0);
               else if (c == cetd_pkg::CHAR_N) add_beat(cetd_pkg::CHAR_LF, 1'b1, 1'b0);
               else if (c == cetd_pkg::CHAR_R) add_beat(cetd_pkg::CHAR_CR, 1'b1, 1'b0);
               else if (c == cetd_pkg::CHAR_X) esc_state = cetd_pkg::ESC_HEX0;
               else add_beat(c, 1'b1, 1'b0);
            end
            cetd_pkg::ESC_HEX0: begin
               h = hex_digit(c);
               if (h >= 0) begin
                  hex_hi    = h[3:0];
                  esc_state = cetd_pkg::ESC_HEX1;
               end else begin
                  add_beat(cetd_pkg::CHAR_BACKSLASH, 1'b1, 1'b0);
                  add_beat(cetd_pkg::CHAR_X, 1'b1, 1'b0);
                  take_plain(c);
               end
            end
            cetd_pkg::ESC_HEX1: begin
               h = hex_digit(c);
               if (h >= 0) begin
                  add_beat({hex_hi, h[3:0]}, 1'b1, 1'b0);
                  esc_state = cetd_pkg::ESC_PLAIN;
                  hex_hi    = '0;
               end else begin
                  add_beat({4'h0, hex_hi}, 1'b1, 1'b0);
                  take_plain(c);
               end
            end
            default: take_plain(c);
         endcase
      end
      // flag the final beat of this input
      if (expected_beats.size() > start_size) begin
         t      = expected_beats[expected_beats.size() - 1];
         t.last = 1'b1;
         expected_beats[expected_beats.size() - 1] = t;
      end
   endtask

   always @(posedge clock) begin
      cetd_pkg::beat_type want;
      if (reset) begin
         esc_state = cetd_pkg::ESC_PLAIN;
         hex_hi    = '0;
         quoted    = 1'b0;
         expected_beats.delete();
      end else begin
         // compare first: a result never belongs to the input taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing predicted, byte %02h",
                                         rsp_out_byte));
            end else begin
               want = expected_beats.pop_front();
               checked_beats++;
               if (rsp_token_end === 1'b1) token_closes++;
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                            rsp_out_byte, want.out_byte));
               if (rsp_byte_valid !== want.byte_valid)
                  report_mismatch($sformatf("byte_valid %b, predicted %b",
                                            rsp_byte_valid, want.byte_valid));
               if (rsp_token_end !== want.token_end)
                  report_mismatch($sformatf("token_end %b, predicted %b",
                                            rsp_token_end, want.token_end));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %b, predicted %b", rsp_last, want.last));
            end
         end
         if (req_valid && !req_stall) predict_beat(req_in_byte, req_end_of_input);
      end
      pending_beats <= expected_beats.size();
   end

endmodule

// ===== tb/c_escape_token_decoder_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c_escape_token_decoder_unit_tb: stimulus and verdict for the token decoder
// Sends a short directed text covering the t, n, r and x escapes, quoting and token
// closing, then random token fragments, with random gaps on the input side
// and random stalls on the result side. Checking lives in the predictor.
// ----------------------------------------------------------------------------
module c_escape_token_decoder_unit_tb;

   localparam int unsigned TARGET_ITEMS = 480;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic [7:0]  req_in_byte      = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        rsp_stall        = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_token_end;
   logic        rsp_last;

   int unsigned error_count;
   int unsigned pending_beats;
   int unsigned checked_beats;
   int unsigned token_closes;
   int unsigned items_sent = 0;
   int unsigned stall_left = 0;
   int unsigned rsp_cycles = 0;
   bit          req_quiet  = 1'b0;
   bit          rsp_quiet  = 1'b0;
   logic [8:0]  opening [0:24];

   always #2 clock = ~clock;

   c_escape_token_decoder_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_token_end    (rsp_token_end),
      .rsp_last         (rsp_last)
   );

   token_decode_predictor i_predictor (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_token_end    (rsp_token_end),
      .rsp_last         (rsp_last),
      .error_count      (error_count),
      .pending_beats    (pending_beats),
      .checked_beats    (checked_beats),
      .token_closes     (token_closes)
   );

   // mostly short gaps, a few long ones, none during a quiet stretch
   function automatic int unsigned pick_gap(input bit quiet);
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 20);
   endfunction

   function automatic logic [7:0] rand_hex();
      int unsigned r;
      r = $urandom_range(0, 21);
      if (r < 10) return 8'(int'("0") + r);
      if (r < 16) return 8'(int'("a") + r - 10);
      return 8'(int'("A") + r - 16);
   endfunction

   function automatic logic [7:0] rand_blank();
      int unsigned r;
      r = $urandom_range(0, 5);
      return (r == 5) ? cetd_pkg::CHAR_SPACE : 8'(cetd_pkg::CHAR_TAB + r);
   endfunction

   // drive one beat and hold it until taken
   task automatic send_beat(input logic [7:0] b, input logic eoi);
      int unsigned gap;
      gap = pick_gap(req_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_in_byte      <= b;
      req_end_of_input <= eoi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (items_sent % 40 == 0) req_quiet = ($urandom_range(0, 3) == 0);
   endtask

   task automatic send_fragment();
      int unsigned kind;
      int unsigned digits;
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
         send_beat(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
      end else if (kind < 40) begin
         send_beat(cetd_pkg::CHAR_BACKSLASH, 1'b0);
         case ($urandom_range(0, 7))
            0: send_beat(cetd_pkg::CHAR_T, 1'b0);
            1: send_beat(cetd_pkg::CHAR_N, 1'b0);
            2: send_beat(cetd_pkg::CHAR_R, 1'b0);
            3: send_beat(cetd_pkg::CHAR_QUOTE, 1'b0);
            4: send_beat(rand_blank(), 1'b0);
            5: send_beat(cetd_pkg::CHAR_BACKSLASH, 1'b0);
            6: send_beat(8'($urandom_range(0, 255)), 1'b1);
            default: send_beat(8'($urandom_range(0, 255)), 1'b0);
         endcase
      end else if (kind < 55) begin
         send_beat(cetd_pkg::CHAR_BACKSLASH, 1'b0);
         send_beat(cetd_pkg::CHAR_X, 1'b0);
         digits = $urandom_range(0, 2);
         repeat (digits) send_beat(rand_hex(), 1'b0);
         // sometimes cut the escape short
         case ($urandom_range(0, 3))
            1: send_beat(8'($urandom_range(0, 255)), 1'b0);
            2: send_beat(8'($urandom_range(0, 255)), 1'b1);
            3: send_beat(rand_blank(), 1'b0);
            default: ;
         endcase
      end else if (kind < 63) begin
         send_beat(cetd_pkg::CHAR_QUOTE, 1'b0);
      end else if (kind < 78) begin
         send_beat(rand_blank(), 1'b0);
      end else if (kind < 84) begin
         send_beat(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         send_beat(8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   // result-side stalls, with quiet stretches now and then
   always @(posedge clock) begin
      rsp_cycles++;
      if (rsp_cycles % 64 == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_gap(rsp_quiet);
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   initial begin
      #2_000_000;
      $display("c_escape_token_decoder_unit_tb: FAIL");
      $finish;
   end

   initial begin
      opening = '{
         {1'b0, 8'h00}, {1'b0, 8'hFF},
         {1'b0, cetd_pkg::CHAR_BACKSLASH}, {1'b0, cetd_pkg::CHAR_T},
         {1'b0, cetd_pkg::CHAR_BACKSLASH}, {1'b0, cetd_pkg::CHAR_N},
         {1'b0, cetd_pkg::CHAR_BACKSLASH}, {1'b0, cetd_pkg::CHAR_R},
         {1'b0, cetd_pkg::CHAR_BACKSLASH}, {1'b0, cetd_pkg::CHAR_X},
         {1'b0, 8'h41}, {1'b0, 8'h66},
         {1'b0, cetd_pkg::CHAR_BACKSLASH}, {1'b0, cetd_pkg::CHAR_X},
         {1'b0, cetd_pkg::CHAR_SPACE},
         {1'b0, cetd_pkg::CHAR_BACKSLASH}, {1'b0, cetd_pkg::CHAR_X},
         {1'b0, 8'h37}, {1'b0, cetd_pkg::CHAR_QUOTE},
         {1'b0, cetd_pkg::CHAR_SPACE}, {1'b0, cetd_pkg::CHAR_QUOTE},
         {1'b0, cetd_pkg::CHAR_SPACE}, {1'b0, cetd_pkg::CHAR_SPACE},
         {1'b0, cetd_pkg::CHAR_BACKSLASH}, {1'b1, 8'h00}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (opening[i]) send_beat(opening[i][7:0], opening[i][8]);
      while (items_sent < TARGET_ITEMS) send_fragment();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      $display("covered %0d input beats, %0d result beats checked, %0d tokens closed",
               items_sent, checked_beats, token_closes);
      if (error_count == 0) begin
         $display("c_escape_token_decoder_unit_tb: PASS");
      end else begin
         $display("c_escape_token_decoder_unit_tb: FAIL");
      end
      $finish;
   end

endmodule
